[hdl/tsq_pkg.sv]
// Shared types and constants for the two-stack queue.
package tsq_pkg;

	localparam int VALUE_W = 32;
	localparam int CFG_W   = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_IN_CAP  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAP = 1'b1;
	localparam logic [CFG_W-1:0]     CAP_RESET   = 5'd16;

	typedef enum logic {
		OP_ADD = 1'b0,
		OP_DEL = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

endpackage

[hdl/tsq_if.sv]
// Request and response channel interfaces for the two-stack queue.
interface tsq_req_if;
	logic                              valid;
	logic                              ready;
	tsq_pkg::opcode_t                  opcode;
	logic signed [tsq_pkg::VALUE_W-1:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface tsq_rsp_if;
	logic                              valid;
	logic                              ready;
	tsq_pkg::status_t                  status;
	logic signed [tsq_pkg::VALUE_W-1:0] data_out;

	modport source (output valid, output status, output data_out, input ready);
	modport sink   (input valid, input status, input data_out, output ready);
endinterface

[hdl/two_stack_fifo_queue_top.sv]
// Add, full and empty responses are registered the cycle after the request. A
// delete reads the output stack and answers from S_POP. A transfer (S_MOVE) comes
// first for a delete on an empty output stack, or an add on a full input stack with
// the output stack empty; that add ends in S_FIN_ADD. One request at a time: the
// memories have one registered read port each; a transfer moves one entry per cycle.
// Reset: counts clear, both capacities return to 16; memories are not cleared.
module two_stack_fifo_queue_top #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tsq_req_if.sink                       req,
	tsq_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [tsq_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [tsq_pkg::CFG_W-1:0]     cfg_wdata
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MOVE,
		S_FIN_ADD,
		S_POP
	} state_t;

	state_t state_q;

	logic [DATA_WIDTH-1:0] in_mem  [DEPTH];
	logic [DATA_WIDTH-1:0] out_mem [DEPTH];
	logic [DATA_WIDTH-1:0] in_rd_q;
	logic [DATA_WIDTH-1:0] out_rd_q;

	logic [tsq_pkg::CFG_W-1:0] in_cap_q;
	logic [tsq_pkg::CFG_W-1:0] out_cap_q;
	logic [CW-1:0]             in_cnt_q;
	logic [CW-1:0]             out_cnt_q;
	logic                      mv_s1;
	tsq_pkg::opcode_t          op_q;
	logic [DATA_WIDTH-1:0]     val_q;

	logic                      res_valid_q;
	tsq_pkg::status_t          res_status_q;
	logic [tsq_pkg::VALUE_W-1:0] res_data_q;

	logic [CW-1:0]         icap;
	logic [CW-1:0]         ocap;
	logic                  in_full;
	logic                  slot_free;
	logic                  accept;
	logic                  mv_done;
	logic                  res_set;
	logic [63:0]           val_ext;
	logic [63:0]           rd_ext;
	logic [DATA_WIDTH-1:0] req_data;
	logic [CW-1:0]         in_top;
	logic [CW-1:0]         out_top;

	logic                  ir_en;
	logic [AW-1:0]         ir_addr;
	logic                  iw_en;
	logic [AW-1:0]         iw_addr;
	logic [DATA_WIDTH-1:0] iw_data;
	logic                  ow_en;
	logic [AW-1:0]         ow_addr;
	logic                  or_en;
	logic [AW-1:0]         or_addr;

	// capacity clamp: zero acts as one, above DEPTH acts as DEPTH
	always_comb begin
		if (in_cap_q == '0) begin
			icap = CW'(1);
		end else if (32'(in_cap_q) > 32'(DEPTH)) begin
			icap = CW'(DEPTH);
		end else begin
			icap = CW'(in_cap_q);
		end
		if (out_cap_q == '0) begin
			ocap = CW'(1);
		end else if (32'(out_cap_q) > 32'(DEPTH)) begin
			ocap = CW'(DEPTH);
		end else begin
			ocap = CW'(out_cap_q);
		end
	end

	assign in_full   = (in_cnt_q >= icap);
	assign slot_free = !res_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && slot_free;
	assign accept    = req.valid && req.ready;
	assign mv_done   = (state_q == S_MOVE) && (in_cnt_q == '0) && !mv_s1;
	assign val_ext   = {32'd0, req.value};
	assign req_data  = val_ext[DATA_WIDTH-1:0];
	assign rd_ext    = 64'(out_rd_q);
	assign in_top    = in_cnt_q - CW'(1);
	assign out_top   = out_cnt_q - CW'(1);

	// a response is loaded on a direct add, full or empty, and on finishing a pop or add
	assign res_set = ((state_q == S_IDLE) && accept &&
			((req.opcode == tsq_pkg::OP_ADD) ? (!in_full || out_cnt_q != '0)
			                                 : (out_cnt_q == '0 && in_cnt_q == '0)))
		|| ((state_q == S_FIN_ADD || state_q == S_POP) && slot_free);

	always_comb begin
		ir_en   = 1'b0;
		ir_addr = in_top[AW-1:0];
		iw_en   = 1'b0;
		iw_addr = in_cnt_q[AW-1:0];
		iw_data = req_data;
		ow_en   = 1'b0;
		ow_addr = out_cnt_q[AW-1:0];
		or_en   = 1'b0;
		or_addr = out_top[AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (accept && req.opcode == tsq_pkg::OP_ADD && !in_full) begin
					iw_en = 1'b1;
				end
				if (accept && req.opcode == tsq_pkg::OP_DEL && out_cnt_q != '0) begin
					or_en = 1'b1;
				end
			end
			S_MOVE: begin
				ir_en = (in_cnt_q != '0);
				ow_en = mv_s1 && (out_cnt_q < ocap);
				if (mv_done && op_q == tsq_pkg::OP_DEL) begin
					or_en = 1'b1;
				end
			end
			S_FIN_ADD: begin
				if (slot_free) begin
					iw_en   = 1'b1;
					iw_addr = '0;
					iw_data = val_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (iw_en) begin
			in_mem[iw_addr] <= iw_data;
		end
		if (ir_en) begin
			in_rd_q <= in_mem[ir_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ow_en) begin
			out_mem[ow_addr] <= in_rd_q;
		end
		if (or_en) begin
			out_rd_q <= out_mem[or_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cap_q  <= tsq_pkg::CAP_RESET;
			out_cap_q <= tsq_pkg::CAP_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				tsq_pkg::CFG_IN_CAP:  in_cap_q  <= cfg_wdata;
				tsq_pkg::CFG_OUT_CAP: out_cap_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.opcode;
			val_q <= req_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			in_cnt_q     <= '0;
			out_cnt_q    <= '0;
			mv_s1        <= 1'b0;
			res_valid_q  <= 1'b0;
			res_status_q <= tsq_pkg::STATUS_OK;
			res_data_q   <= '0;
		end else begin
			mv_s1 <= (state_q == S_MOVE) && ir_en;
			if (res_set) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_data_q <= '0;
						if (req.opcode == tsq_pkg::OP_ADD) begin
							if (!in_full) begin
								in_cnt_q     <= in_cnt_q + CW'(1);
								res_status_q <= tsq_pkg::STATUS_OK;
							end else if (out_cnt_q != '0) begin
								res_status_q <= tsq_pkg::STATUS_FULL;
							end else begin
								state_q <= S_MOVE;
							end
						end else begin
							if (out_cnt_q != '0) begin
								out_cnt_q <= out_top;
								state_q   <= S_POP;
							end else if (in_cnt_q != '0) begin
								state_q <= S_MOVE;
							end else begin
								res_status_q <= tsq_pkg::STATUS_EMPTY;
							end
						end
					end
				end
				S_MOVE: begin
					if (ir_en) begin
						in_cnt_q <= in_top;
					end
					if (ow_en) begin
						out_cnt_q <= out_cnt_q + CW'(1);
					end
					if (mv_done) begin
						if (op_q == tsq_pkg::OP_ADD) begin
							state_q <= S_FIN_ADD;
						end else begin
							out_cnt_q <= out_top;
							state_q   <= S_POP;
						end
					end
				end
				S_FIN_ADD: begin
					if (slot_free) begin
						in_cnt_q     <= CW'(1);
						res_status_q <= tsq_pkg::STATUS_OK;
						res_data_q   <= '0;
						state_q      <= S_IDLE;
					end
				end
				S_POP: begin
					if (slot_free) begin
						res_status_q <= tsq_pkg::STATUS_OK;
						res_data_q   <= rd_ext[tsq_pkg::VALUE_W-1:0];
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid    = res_valid_q;
	assign rsp.status   = res_status_q;
	assign rsp.data_out = res_data_q;

	a_in_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(in_cnt_q) <= 32'(DEPTH))
		else $error("input stack count above depth");

	a_out_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(out_cnt_q) <= 32'(DEPTH))
		else $error("output stack count above depth");

	a_pop_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP && $past(state_q) != S_POP) |-> $past(or_en))
		else $error("pop entered without an output stack read");

	a_move_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mv_s1 |-> !req.ready)
		else $error("request taken during a stack transfer");

endmodule

[dv/tb.sv]
// Self-checking testbench for the two-stack queue: directed and random requests with stalls.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;

	typedef struct {
		tsq_pkg::opcode_t                   op;
		logic signed [tsq_pkg::VALUE_W-1:0] val;
	} queue_req_t;

	typedef struct {
		tsq_pkg::status_t                   status;
		logic signed [tsq_pkg::VALUE_W-1:0] data;
	} queue_rsp_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [tsq_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [tsq_pkg::CFG_W-1:0]     cfg_wdata;

	tsq_req_if req_if ();
	tsq_rsp_if rsp_if ();

	two_stack_fifo_queue_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state
	logic [tsq_pkg::VALUE_W-1:0] in_stack [DEPTH];
	logic [tsq_pkg::VALUE_W-1:0] out_stack [DEPTH];
	int                          in_fill;
	int                          out_fill;
	logic [tsq_pkg::CFG_W-1:0]   in_cap_reg;
	logic [tsq_pkg::CFG_W-1:0]   out_cap_reg;

	queue_req_t pending_reqs [$];
	queue_rsp_t expected_rsps [$];
	queue_req_t cur_req;
	int         gap_left;
	int         stall_left;
	int         accepted = 0;
	int         errors = 0;
	logic       hold_off = 1'b0;

	function automatic int usable_cap(logic [tsq_pkg::CFG_W-1:0] c);
		if (c < 1)
			return 1;
		if (c > DEPTH)
			return DEPTH;
		return int'(c);
	endfunction

	// top entry first; entries that find the output stack full are lost
	function automatic void shift_across();
		int ocap;
		ocap = usable_cap(out_cap_reg);
		while (in_fill > 0) begin
			in_fill--;
			if (out_fill < ocap) begin
				out_stack[out_fill] = in_stack[in_fill];
				out_fill++;
			end
		end
	endfunction

	function automatic void predict_queue_op(queue_req_t r);
		queue_rsp_t res;
		res.status = tsq_pkg::STATUS_OK;
		res.data = '0;
		if (r.op == tsq_pkg::OP_ADD) begin
			if (in_fill < usable_cap(in_cap_reg)) begin
				in_stack[in_fill] = r.val;
				in_fill++;
			end else if (out_fill != 0) begin
				res.status = tsq_pkg::STATUS_FULL;
			end else begin
				shift_across();
				in_stack[0] = r.val;
				in_fill = 1;
			end
		end else begin
			if (out_fill == 0 && in_fill != 0)
				shift_across();
			if (out_fill != 0) begin
				out_fill--;
				res.data = out_stack[out_fill];
			end else begin
				res.status = tsq_pkg::STATUS_EMPTY;
			end
		end
		expected_rsps.push_back(res);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic logic [tsq_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_req(tsq_pkg::opcode_t op, logic [tsq_pkg::VALUE_W-1:0] val);
		queue_req_t r;
		r.op = op;
		r.val = val;
		pending_reqs.push_back(r);
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_caps(logic [tsq_pkg::CFG_W-1:0] icap,
			logic [tsq_pkg::CFG_W-1:0] ocap);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= tsq_pkg::CFG_IN_CAP;
		cfg_wdata <= icap;
		in_cap_reg = icap;
		@(posedge clk);
		cfg_idx <= tsq_pkg::CFG_OUT_CAP;
		cfg_wdata <= ocap;
		out_cap_reg = ocap;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// runs of adds or deletes so the stacks fill, transfer and drain
	task automatic queue_random_run(int n);
		int made;
		int run;
		int add_pct;
		tsq_pkg::opcode_t op;
		made = 0;
		add_pct = $urandom_range(65, 35);
		while (made < n) begin
			op = ($urandom_range(99) < add_pct) ? tsq_pkg::OP_ADD : tsq_pkg::OP_DEL;
			run = $urandom_range(20, 1);
			while (run > 0 && made < n) begin
				add_req(op, pick_value());
				run--;
				made++;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = tsq_pkg::CFG_IN_CAP;
		cfg_wdata = '0;
		req_if.valid = 1'b0;
		req_if.opcode = tsq_pkg::OP_ADD;
		req_if.value = '0;
		rsp_if.ready = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		logic [tsq_pkg::CFG_W-1:0] icaps [8];
		logic [tsq_pkg::CFG_W-1:0] ocaps [8];
		icaps = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd4, 5'd16, 5'd3, 5'd17};
		ocaps = '{5'd16, 5'd0, 5'd31, 5'd16, 5'd2, 5'd1, 5'd5, 5'd20};
		in_fill = 0;
		out_fill = 0;
		in_cap_reg = tsq_pkg::CAP_RESET;
		out_cap_reg = tsq_pkg::CAP_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty, extremes, transfer on add, full, FIFO order, transfer on delete
		write_caps(5'd2, 5'd2);
		add_req(tsq_pkg::OP_DEL, '1);
		add_req(tsq_pkg::OP_ADD, 32'h7fff_ffff);
		add_req(tsq_pkg::OP_ADD, 32'h8000_0000);
		add_req(tsq_pkg::OP_ADD, '0);
		add_req(tsq_pkg::OP_ADD, '1);
		add_req(tsq_pkg::OP_ADD, 32'h0000_0001);
		add_req(tsq_pkg::OP_DEL, '0);
		add_req(tsq_pkg::OP_DEL, '0);
		add_req(tsq_pkg::OP_DEL, '0);
		add_req(tsq_pkg::OP_DEL, '0);
		add_req(tsq_pkg::OP_DEL, '0);
		wait_idle();

		// lossy transfer: output stack smaller than input stack
		write_caps(5'd3, 5'd1);
		add_req(tsq_pkg::OP_ADD, 32'h1111_1111);
		add_req(tsq_pkg::OP_ADD, 32'h2222_2222);
		add_req(tsq_pkg::OP_ADD, 32'h3333_3333);
		add_req(tsq_pkg::OP_DEL, '0);
		add_req(tsq_pkg::OP_DEL, '0);
		add_req(tsq_pkg::OP_ADD, 32'h5555_aaaa);
		add_req(tsq_pkg::OP_DEL, '0);
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			write_caps(icaps[p], ocaps[p]);
			queue_random_run(150);
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("two_stack_fifo_queue_top: match");
		else
			$display("two_stack_fifo_queue_top: mismatch");
		$finish;
	end

	// long response hold-off so the block backs up onto its request side
	initial begin
		@(posedge arst_n);
		while (accepted < 500)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("two_stack_fifo_queue_top: mismatch");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				predict_queue_op(cur_req);
				accepted <= accepted + 1;
			end
			if (!req_if.valid || req_if.ready) begin
				if (gap_left > 0 || pending_reqs.size() == 0) begin
					if (gap_left > 0)
						gap_left <= gap_left - 1;
					req_if.valid <= 1'b0;
				end else begin
					cur_req = pending_reqs.pop_front();
					req_if.valid <= 1'b1;
					req_if.opcode <= cur_req.op;
					req_if.value <= cur_req.val;
					gap_left <= pick_gap();
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		queue_rsp_t want;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected response, status %0d data %0d", $time,
						rsp_if.status, rsp_if.data_out);
					errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_if.status !== want.status) begin
						$display("%0t: status expected %0d got %0d", $time,
							want.status, rsp_if.status);
						errors++;
					end
					if (rsp_if.data_out !== want.data) begin
						$display("%0t: data_out expected %0d got %0d", $time,
							want.data, rsp_if.data_out);
						errors++;
					end
				end
			end
			if (hold_off) begin
				rsp_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
				stall_left <= pick_gap();
			end
		end
	end

endmodule
